FILE: rtl/mlp_pkg.sv
// Package for the MLP forward pass: constants, payload structs and the sigmoid table.
// Used by mlp_cfg, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
package mlp_pkg;
  localparam int MAX_NODES       = 16;
  localparam int MAX_HIDDEN      = 4;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int NODE_W          = $clog2(MAX_NODES);
  localparam int LAYER_SLOTS     = MAX_HIDDEN + 1;
  localparam int WADDR_W         = $clog2(LAYER_SLOTS * MAX_NODES * MAX_NODES);
  localparam int BADDR_W         = $clog2(LAYER_SLOTS * MAX_NODES);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 5;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_INPUT  = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HSIZE_1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HSIZE_2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HSIZE_3      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HSIZE_4      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 3'd6;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         layer;
    logic [3:0]         neuron_index;
    logic [3:0]         source_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  output_index;
    logic [12:0] output_value;
    logic        last;
  } out_item_t;

  // Layer sizes already clamped to their legal ranges.
  typedef struct packed {
    logic [4:0] input_count;
    logic [2:0] hidden_count;
    logic [4:0] hsize1;
    logic [4:0] hsize2;
    logic [4:0] hsize3;
    logic [4:0] hsize4;
    logic [4:0] output_count;
  } cfg_t;

  // Unsigned quotient by shift and subtract; used only while the table is built.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table built at elaboration the same way as the fixed-point derivation.
  function automatic logic [12:0] sig_entry(input int i);
    longint unsigned off, a, u, term, e, den, num;
    longint          sum, x;
    off  = ((2 * i + 1) * 32768) >> $clog2(SIGMOID_ENTRIES);
    x    = longint'(off) - 32768;
    a    = (x < 0) ? longint'(-x) : longint'(x);
    u    = a << 14;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int k = 1; k <= 10; k++) begin
      term = udiv((term * u) >> 30, k);
      if ((k & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    e = (sum < 0) ? 64'd0 : longint'(sum);
    for (int r = 0; r < 4; r++) e = (e * e + (64'd1 << 29)) >> 30;
    den = (64'd1 << 30) + e;
    num = (x >= 0) ? (64'd4096 << 30) : 64'd4096 * e;
    return 13'(udiv(num + (den >> 1), den));
  endfunction

  typedef logic [12:0] sig_tab_t [SIGMOID_ENTRIES];

  function automatic sig_tab_t build_sig();
    sig_tab_t t;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) t[i] = sig_entry(i);
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig();
endpackage

FILE: rtl/mlp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/mlp_cfg.sv
// Configuration register file for the MLP; clamps the counts on write.
// Depends on mlp_pkg.
`timescale 1ns / 1ps
module mlp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mlp_pkg::cfg_t                   cfg
);
  import mlp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic [4:0] cnt5;
  logic [2:0] cnt3;

  always_comb begin
    cnt5 = (cfg_data == 5'd0) ? 5'd1 : (cfg_data > 5'(MAX_NODES)) ? 5'(MAX_NODES) : cfg_data;
    cnt3 = (cfg_data[2:0] == 3'd0) ? 3'd1 : (cfg_data[2:0] > 3'd4) ? 3'd4 : cfg_data[2:0];
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_INPUT_COUNT:  cfg_nxt.input_count  = cnt5;
        REG_HIDDEN_COUNT: cfg_nxt.hidden_count = cnt3;
        REG_HSIZE_1:      cfg_nxt.hsize1       = cnt5;
        REG_HSIZE_2:      cfg_nxt.hsize2       = cnt5;
        REG_HSIZE_3:      cfg_nxt.hsize3       = cnt5;
        REG_HSIZE_4:      cfg_nxt.hsize4       = cnt5;
        REG_OUTPUT_COUNT: cfg_nxt.output_count = cnt5;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{input_count: 5'd16, hidden_count: 3'd1, hsize1: 5'd16, hsize2: 5'd16,
                 hsize3: 5'd16, hsize4: 5'd16, output_count: 5'd16};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

FILE: rtl/mlp_feedforward_sigmoid.sv
// Top level of the MLP forward pass: command decode, memories and the MAC sequencer.
// Depends on mlp_pkg, mlp_ram and mlp_cfg.
//
//  channel | direction | handshake        | payload
//  in_     | input     | valid / stall    | in_item_t
//  out_    | output    | valid / stall    | out_item_t
//  cfg_    | input     | valid / ready    | index, data
//
// Loads are taken while idle; a run holds the input off until its last result is emitted.
// For each neuron a run goes through the bias, one weight read per source, a drain
// of the MAC pipeline and the result; in the output layer the emit follows.
// The emit step waits only while the previous result beat is still stalled.
// Reset is synchronous; memories are not cleared and must be written before use.
`timescale 1ns / 1ps
module mlp_feedforward_sigmoid (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mlp_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mlp_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mlp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BIAS = 5'b00010,
    S_MAC  = 5'b00100,
    S_DONE = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  cfg_t   cfg;

  logic [2:0]        layer_r, layer_nxt;
  logic [NODE_W-1:0] j_r, j_nxt;
  logic [NODE_W:0]   i_r, i_nxt;
  logic              rd_v_r;            // a weight/activation pair arrives this cycle
  logic signed [39:0] acc_r, acc_nxt;
  logic signed [31:0] prod_r;
  logic              prod_v_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic in_acc;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  mlp_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  // Sizes of the current layer.
  logic [4:0] ncur, nout;
  logic       last_layer;
  always_comb begin
    last_layer = (layer_r == cfg.hidden_count);
    if (layer_r == 3'd0) ncur = cfg.input_count;
    else begin
      unique case (layer_r)
        3'd1:    ncur = cfg.hsize1;
        3'd2:    ncur = cfg.hsize2;
        3'd3:    ncur = cfg.hsize3;
        default: ncur = cfg.hsize4;
      endcase
    end
    if (last_layer) nout = cfg.output_count;
    else begin
      unique case (layer_r)
        3'd0:    nout = cfg.hsize1;
        3'd1:    nout = cfg.hsize2;
        3'd2:    nout = cfg.hsize3;
        default: nout = cfg.hsize4;
      endcase
    end
  end

  // Memories.
  logic               w_we, b_we;
  logic [WADDR_W-1:0] w_waddr, w_raddr;
  logic [BADDR_W-1:0] b_waddr, b_raddr;
  logic signed [15:0] w_rdata, b_rdata;
  logic [NODE_W-1:0]  rd_i;
  logic               ld_ok;

  assign ld_ok = (in_data.layer <= 3'(MAX_HIDDEN));
  assign rd_i  = i_r[NODE_W-1:0];
  assign w_we    = in_acc && cmd_t'(in_data.command) == CMD_WEIGHT && ld_ok;
  assign w_waddr = WADDR_W'({in_data.layer, in_data.neuron_index, in_data.source_index});
  assign w_raddr = WADDR_W'({layer_r, j_r, rd_i});
  assign b_we    = in_acc && cmd_t'(in_data.command) == CMD_BIAS && ld_ok;
  assign b_waddr = BADDR_W'({in_data.layer, in_data.neuron_index});
  // The bias is addressed from the next-state layer and neuron so that its data is ready in S_BIAS.
  assign b_raddr = BADDR_W'({layer_nxt, j_nxt});

  mlp_ram #(.WIDTH(16), .DEPTH(LAYER_SLOTS * MAX_NODES * MAX_NODES)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_data.value),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  mlp_ram #(.WIDTH(16), .DEPTH(LAYER_SLOTS * MAX_NODES)) u_bram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_data.value),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Result of one neuron: round, saturate and look up the sigmoid.
  logic signed [39:0] rnd;
  logic signed [27:0] q;
  logic signed [15:0] sat;
  logic [15:0]        biased;
  logic [12:0]        sig;
  always_comb begin
    rnd    = acc_r + 40'sd2048;
    q      = 28'(rnd >>> 12);
    sat    = (q > 28'sd32767) ? 16'sd32767 : (q < -28'sd32768) ? -16'sd32768 : 16'(q);
    biased = 16'(sat) ^ 16'h8000;
    sig    = SIG_TAB[biased[15:8]];
  end

  // Activations: input loads fill the input RAM, which a run never overwrites.
  // Neuron results go to a scratch RAM of two banks; layer L writes bank L[0]
  // and reads the bank that layer L-1 wrote.
  logic              in_we, s_we;
  logic [NODE_W:0]   s_waddr, s_raddr;
  logic [15:0]       in_rdata, s_rdata;
  assign in_we   = in_acc && cmd_t'(in_data.command) == CMD_INPUT;
  assign s_we    = (state_r == S_DONE);
  assign s_waddr = {layer_r[0], j_r};
  assign s_raddr = {!layer_r[0], rd_i};

  mlp_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_iram (
    .clk(clk), .we(in_we), .waddr(in_data.neuron_index), .wdata(in_data.value),
    .raddr(rd_i), .rdata(in_rdata)
  );
  mlp_ram #(.WIDTH(16), .DEPTH(2 * MAX_NODES)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata({3'b000, sig}),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic signed [15:0] act_rd;
  assign act_rd = (layer_r == 3'd0) ? in_rdata : s_rdata;

  // Sequencer.
  logic out_take;
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    state_nxt  = state_r;
    layer_nxt  = layer_r;
    j_nxt      = j_r;
    i_nxt      = i_r;
    acc_nxt    = acc_r;
    if (prod_v_r) acc_nxt = acc_r + 40'(prod_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && cmd_t'(in_data.command) == CMD_RUN) begin
          state_nxt = S_BIAS;
          layer_nxt = 3'd0;
          j_nxt     = '0;
          i_nxt     = '0;
        end
      end
      S_BIAS: begin
        // Bias read issued last cycle is now on b_rdata; weights stream from here.
        acc_nxt   = 40'(b_rdata) <<< 12;
        state_nxt = S_MAC;
        i_nxt     = '0;
      end
      S_MAC: begin
        if (i_r < ncur) i_nxt = i_r + 1'b1;
        else if (!rd_v_r && !prod_v_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (last_layer) state_nxt = S_EMIT;
        else if ({1'b0, j_r} + 5'd1 == nout) begin
          layer_nxt = layer_r + 3'd1;
          j_nxt     = '0;
          state_nxt = S_BIAS;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_BIAS;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_take) begin
          if ({1'b0, j_r} + 5'd1 == nout) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_BIAS;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      layer_r     <= '0;
      j_r         <= '0;
      i_r         <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      layer_r  <= layer_nxt;
      j_r      <= j_nxt;
      i_r      <= i_nxt;
      rd_v_r   <= (state_r == S_MAC) && (i_r < ncur);
      prod_v_r <= rd_v_r;
      if (state_r == S_EMIT && (!out_valid_r || out_take)) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= w_rdata * act_rd;
    if (state_r == S_EMIT && (!out_valid_r || out_take)) begin
      out_r.output_index <= j_r;
      out_r.output_value <= sig;
      out_r.last         <= ({1'b0, j_r} + 5'd1 == nout);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The sequencer must not emit while a product is still in flight.
  a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !prod_v_r && !rd_v_r)
    else $error("emit with MAC pipeline busy");
  // Inputs are only taken while idle.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_acc)
    else $error("item accepted during a run");
  // A result beat that is stalled keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
endmodule

FILE: bench/mlp_feedforward_sigmoid_tb.sv
// Self-checking testbench for the MLP forward pass with sigmoid activation.
// Drives loads and runs through queued beats, predicts every result beat and
// compares it field by field; depends on mlp_pkg and mlp_feedforward_sigmoid.
`timescale 1ns / 1ps
module mlp_feedforward_sigmoid_tb;
  import mlp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mlp_feedforward_sigmoid DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's state and registers.
  logic signed [15:0] weight_mem [LAYER_SLOTS*MAX_NODES*MAX_NODES];
  logic signed [15:0] bias_mem [LAYER_SLOTS*MAX_NODES];
  logic signed [15:0] input_act [MAX_NODES];
  logic [4:0] size_regs [7];
  int sig_lut [SIGMOID_ENTRIES];

  in_item_t pending_beats [$];
  out_item_t expected_beats [$];
  int error_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int seg_left = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;

  function automatic int sigmoid_point(int i);
    longint x, acc;
    longint unsigned mag, u, term, e, den, num;
    x = longint'(((2 * i + 1) * 32768) / SIGMOID_ENTRIES) - 32768;
    mag = (x < 0) ? -x : x;
    u = mag << 14;
    term = 64'd1 << 30;
    acc = term;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * u) >> 30) / k;
      acc = (k % 2) ? acc - longint'(term) : acc + longint'(term);
    end
    e = (acc < 0) ? 0 : acc;
    for (int r = 0; r < 4; r++) e = (e * e + (64'd1 << 29)) >> 30;
    den = (64'd1 << 30) + e;
    num = (x >= 0) ? (64'd4096 << 30) : 64'd4096 * e;
    return int'((num + den / 2) / den);
  endfunction

  function automatic int clamp_size(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void add_pending(input in_item_t it);
    pending_beats = {pending_beats, it};
  endfunction

  // Updates the shadow state for one accepted beat and queues the result beats of a run.
  task automatic apply_beat(input in_item_t it);
    int hcount, ncur, nout;
    int cur [MAX_NODES];
    int nxt [MAX_NODES];
    longint acc, q;
    out_item_t r;
    case (cmd_t'(it.command))
      CMD_WEIGHT: begin
        if (it.layer <= MAX_HIDDEN)
          weight_mem[(it.layer * MAX_NODES + it.neuron_index) * MAX_NODES + it.source_index]
            = it.value;
      end
      CMD_BIAS: begin
        if (it.layer <= MAX_HIDDEN) bias_mem[it.layer * MAX_NODES + it.neuron_index] = it.value;
      end
      CMD_INPUT: input_act[it.neuron_index] = it.value;
      default: begin
        hcount = clamp_size(size_regs[REG_HIDDEN_COUNT] & 5'd7, 4);
        ncur = clamp_size(size_regs[REG_INPUT_COUNT], MAX_NODES);
        for (int i = 0; i < ncur; i++) cur[i] = input_act[i];
        for (int l = 0; l <= hcount; l++) begin
          nout = (l < hcount) ? clamp_size(size_regs[REG_HSIZE_1 + l], MAX_NODES)
                              : clamp_size(size_regs[REG_OUTPUT_COUNT], MAX_NODES);
          for (int j = 0; j < nout; j++) begin
            acc = longint'(bias_mem[l * MAX_NODES + j]) * 4096;
            for (int i = 0; i < ncur; i++)
              acc += longint'(weight_mem[(l * MAX_NODES + j) * MAX_NODES + i]) * cur[i];
            q = (acc + 2048) >>> 12;
            if (q < -32768) q = -32768;
            if (q > 32767) q = 32767;
            nxt[j] = sig_lut[(q + 32768) >> 8];
          end
          for (int j = 0; j < nout; j++) cur[j] = nxt[j];
          ncur = nout;
        end
        for (int j = 0; j < ncur; j++) begin
          r.output_index = 4'(j);
          r.output_value = 13'(cur[j]);
          r.last = (j == ncur - 1);
          expected_beats = {expected_beats, r};
        end
      end
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_beat(in_data);
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_beats.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern in segments, plus one long hold-off while runs are queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_armed && !hold_done && out_valid) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(10, 80);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: index %0d value %0d",
               out_data.output_index, out_data.output_value);
        error_count++;
      end else begin
        if (out_data.output_index !== expected_beats[0].output_index) begin
          $error("output_index expected %0d actual %0d",
                 expected_beats[0].output_index, out_data.output_index);
          error_count++;
        end
        if (out_data.output_value !== expected_beats[0].output_value) begin
          $error("output_value expected %0d actual %0d",
                 expected_beats[0].output_value, out_data.output_value);
          error_count++;
        end
        if (out_data.last !== expected_beats[0].last) begin
          $error("last expected %0d actual %0d", expected_beats[0].last, out_data.last);
          error_count++;
        end
        void'(expected_beats.pop_front());
      end
    end
  end

  // One register write, with the valid dropped again on the configuration port before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_regs[idx] = d;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_item_t make_beat(input cmd_t c, input int lyr, input int n,
                                         input int s, input int v);
    in_item_t it;
    it.command = c;
    it.layer = 3'(lyr);
    it.neuron_index = 4'(n);
    it.source_index = 4'(s);
    it.value = 16'(v);
    return it;
  endfunction

  function automatic int random_value();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                       : int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic in_item_t random_beat();
    int pick, lyr;
    pick = $urandom_range(0, 99);
    lyr = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    if (pick < 40) return make_beat(CMD_WEIGHT, lyr, $urandom_range(0, 15),
                                    $urandom_range(0, 15), random_value());
    if (pick < 58) return make_beat(CMD_BIAS, lyr, $urandom_range(0, 15),
                                    $urandom_range(0, 15), random_value());
    if (pick < 82) return make_beat(CMD_INPUT, $urandom_range(0, 7), $urandom_range(0, 15),
                                    $urandom_range(0, 15), random_value());
    return make_beat(CMD_RUN, $urandom_range(0, 7), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 65535));
  endfunction

  initial begin
    int hc, eff;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) sig_lut[i] = sigmoid_point(i);
    size_regs[REG_INPUT_COUNT] = 5'd16;
    size_regs[REG_HIDDEN_COUNT] = 5'd1;
    for (int i = REG_HSIZE_1; i <= REG_OUTPUT_COUNT; i++) size_regs[i] = 5'd16;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Three inputs, three neurons per layer; layer 1 also holds sixteen neurons so
    // that a single hidden layer can feed the largest output layer.
    write_reg(REG_INPUT_COUNT, 5'd3);
    for (int i = REG_HSIZE_1; i <= REG_OUTPUT_COUNT; i++) write_reg(3'(i), 5'd3);

    // Every store entry that a run can read is written before the first run.
    for (int l = 0; l < LAYER_SLOTS; l++)
      for (int n = 0; n < ((l == 1) ? MAX_NODES : 3); n++) begin
        add_pending(make_beat(CMD_BIAS, l, n, 0, random_value()));
        for (int s = 0; s < 3; s++)
          add_pending(make_beat(CMD_WEIGHT, l, n, s, random_value()));
      end
    for (int n = 0; n < 3; n++)
      add_pending(make_beat(CMD_INPUT, 0, n, 0, random_value()));
    add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));

    // Directed: extreme activations, weights and biases, and ignored loads.
    add_pending(make_beat(CMD_INPUT, 7, 0, 15, 32767));
    add_pending(make_beat(CMD_INPUT, 0, 2, 0, -32768));
    add_pending(make_beat(CMD_WEIGHT, 0, 0, 0, 32767));
    add_pending(make_beat(CMD_WEIGHT, 0, 2, 2, -32768));
    add_pending(make_beat(CMD_BIAS, 1, 15, 15, 32767));
    add_pending(make_beat(CMD_BIAS, 1, 0, 0, -32768));
    add_pending(make_beat(CMD_WEIGHT, 4, 2, 2, 16'h7fff));
    add_pending(make_beat(CMD_WEIGHT, 5, 1, 1, 1234));
    add_pending(make_beat(CMD_BIAS, 7, 2, 0, -1234));
    add_pending(make_beat(CMD_RUN, 7, 15, 15, 65535));
    add_pending(make_beat(CMD_BIAS, 0, 1, 0, 0));
    add_pending(make_beat(CMD_INPUT, 0, 1, 0, 0));
    add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
    wait_idle();

    // Register values above range saturate: 31 outputs give 16, 7 hidden layers give 4.
    write_reg(REG_OUTPUT_COUNT, 5'd31);
    add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
    add_pending(make_beat(CMD_WEIGHT, 1, 15, 2, -32768));
    add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
    wait_idle();
    write_reg(REG_OUTPUT_COUNT, 5'd3);
    write_reg(REG_HIDDEN_COUNT, 5'd7);
    add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
    wait_idle();

    // Smallest network: zero saturates to one neuron per layer.
    for (int i = REG_INPUT_COUNT; i <= REG_OUTPUT_COUNT; i++) write_reg(3'(i), 5'd0);
    add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
    add_pending(make_beat(CMD_INPUT, 0, 0, 0, 32767));
    add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
    wait_idle();

    hold_armed = 1'b1;
    for (int p = 0; p < 4; p++) begin
      hc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      if (p == 3) hc = 1;
      eff = clamp_size(hc, 4);
      write_reg(REG_INPUT_COUNT, 5'($urandom_range(1, 3)));
      write_reg(REG_HIDDEN_COUNT, 5'(hc));
      for (int i = REG_HSIZE_1; i <= REG_HSIZE_4; i++) write_reg(3'(i), 5'($urandom_range(1, 3)));
      if (eff == 1)
        write_reg(REG_OUTPUT_COUNT, (p == 3) ? 5'd16 : 5'($urandom_range(1, 16)));
      else
        write_reg(REG_OUTPUT_COUNT, 5'($urandom_range(1, 3)));
      add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
      for (int k = 0; k < 15; k++) add_pending(random_beat());
      add_pending(make_beat(CMD_RUN, 0, 0, 0, 0));
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("mlp_feedforward_sigmoid test passed");
    end else begin
      $display("mlp_feedforward_sigmoid test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mlp_feedforward_sigmoid test failed");
    $finish;
  end
endmodule
